@@ hdl/gbc_pkg.sv @@
// Shared types and constants of the gyro bias calibrator.
// Used by every module of the block; depends on nothing else.

package gbc_pkg;

  localparam int AXES = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] STILL_SAMPLES_RST = 16'd2000;
  localparam logic [15:0] MAX_SAMPLES_RST   = 16'd15000;
  localparam logic [15:0] TRACK_STEP_RST    = 16'd6554;
  localparam logic [14:0] TRACK_CLAMP_RST   = 15'd800;
  localparam logic [14:0] MOTION_MARGIN_RST = 15'd100;
  localparam logic [15:0] BIAS_GAIN_RST     = 16'd131;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } gbc_op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STILL_SAMPLES = 3'd0,
    REG_MAX_SAMPLES   = 3'd1,
    REG_TRACK_STEP    = 3'd2,
    REG_TRACK_CLAMP   = 3'd3,
    REG_MOTION_MARGIN = 3'd4,
    REG_BIAS_GAIN     = 3'd5
  } gbc_reg_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } gbc_in_t;

  typedef struct packed {
    logic               busy_res;
    logic               done_res;
    logic               success;
    logic               motion;
    logic signed [31:0] bias_x;
    logic signed [31:0] bias_y;
    logic signed [31:0] bias_z;
  } gbc_out_t;

  typedef struct packed {
    logic [15:0] still_samples;
    logic [15:0] max_samples;
    logic [15:0] track_step;
    logic [14:0] track_clamp;
    logic [14:0] motion_margin;
    logic [15:0] bias_gain;
  } gbc_cfg_t;

  // Per-item commands from the run control to every axis lane.
  typedef struct packed {
    logic load;  // start item: tracker takes the stored bias
    logic upd;   // sample item during a run
    logic clr;   // run timed out: bias goes to zero
  } gbc_lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic success;
    logic motion;
  } gbc_flags_t;

endpackage

@@ hdl/gbc_lane.sv @@
// One axis lane of the gyro bias calibrator: tracker, motion test and bias low-pass.
// Depends on gbc_pkg.

module gbc_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gbc_pkg::gbc_lane_ctl_t ctl,
  input  gbc_pkg::gbc_cfg_t     cfg,
  input  logic signed [15:0]    rate,
  output logic                  motion,
  output logic signed [31:0]    bias_nxt
);

  logic signed [31:0] bias_r;
  logic signed [31:0] trk_r;
  logic signed [31:0] trk_nxt;

  logic signed [33:0] s34;
  logic signed [33:0] t34;
  logic signed [33:0] b34;
  logic signed [33:0] step34;
  logic signed [33:0] lim34;
  logic signed [33:0] t_up;
  logic signed [33:0] t_dn;
  logic signed [33:0] t_cl;
  logic [32:0]        abs_s;
  logic [32:0]        abs_t;
  logic [33:0]        thr;
  logic signed [33:0] diff;
  logic signed [16:0] gain;
  logic signed [50:0] prod;
  logic signed [35:0] sum;
  logic signed [31:0] bias_upd;

  assign s34    = {{2{rate[15]}}, rate, 16'h0000};
  assign t34    = {{2{trk_r[31]}}, trk_r};
  assign b34    = {{2{bias_r[31]}}, bias_r};
  assign step34 = {18'd0, cfg.track_step};
  assign lim34  = {3'd0, cfg.track_clamp, 16'h0000};

  // The tracker steps up, then down against the stepped value, then clamps.
  assign t_up = (s34 > t34) ? t34 + step34 : t34;
  assign t_dn = (s34 < t_up) ? t_up - step34 : t_up;

  always_comb begin
    if (t_dn > lim34) begin
      t_cl = lim34;
    end else if (t_dn < -lim34) begin
      t_cl = -lim34;
    end else begin
      t_cl = t_dn;
    end
  end

  assign abs_s  = s34[33] ? 33'(-s34) : s34[32:0];
  assign abs_t  = t_cl[33] ? 33'(-t_cl) : t_cl[32:0];
  assign thr    = {3'd0, cfg.motion_margin, 16'h0000} + {1'b0, abs_t};
  assign motion = {1'b0, abs_s} > thr;

  // Low-pass step: the arithmetic shift floors the Q0.16 product.
  assign diff = s34 - b34;
  assign gain = $signed({1'b0, cfg.bias_gain});
  assign prod = diff * gain;
  assign sum  = {{4{bias_r[31]}}, bias_r} + {prod[50], prod[50:16]};

  always_comb begin
    if (sum[35:31] != {5{sum[35]}}) begin
      bias_upd = sum[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      bias_upd = sum[31:0];
    end
  end

  always_comb begin
    if (ctl.clr) begin
      bias_nxt = '0;
    end else if (ctl.upd && !motion) begin
      bias_nxt = bias_upd;
    end else begin
      bias_nxt = bias_r;
    end
  end

  always_comb begin
    if (ctl.load) begin
      trk_nxt = bias_r;
    end else if (ctl.upd) begin
      trk_nxt = t_cl[31:0];
    end else begin
      trk_nxt = trk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      trk_r  <= '0;
    end else begin
      bias_r <= bias_nxt;
      trk_r  <= trk_nxt;
    end
  end

endmodule

@@ hdl/gbc_ctrl.sv @@
// Run control of the gyro bias calibrator: merges lane motion, counts samples, ends runs.
// Depends on gbc_pkg.

module gbc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic                         op,
  input  logic [gbc_pkg::AXES-1:0]     lane_motion,
  input  gbc_pkg::gbc_cfg_t            cfg,
  output gbc_pkg::gbc_lane_ctl_t       ctl,
  output gbc_pkg::gbc_flags_t          flags
);

  logic        running_r;
  logic        running_nxt;
  logic [15:0] still_r;
  logic [15:0] still_nxt;
  logic [15:0] total_r;
  logic [15:0] total_nxt;
  logic        start;
  logic        upd;
  logic        any_motion;
  logic [15:0] still_new;
  logic [15:0] total_new;
  logic        succ;
  logic        fail;

  assign start      = fire && (gbc_pkg::gbc_op_t'(op) == gbc_pkg::OP_START);
  assign upd        = fire && (gbc_pkg::gbc_op_t'(op) == gbc_pkg::OP_SAMPLE) && running_r;
  assign any_motion = |lane_motion;

  assign still_new = any_motion ? '0 : ((&still_r) ? still_r : still_r + 16'd1);
  assign total_new = (&total_r) ? total_r : total_r + 16'd1;

  // Success wins when both limits are reached on the same sample.
  assign succ = still_new >= cfg.still_samples;
  assign fail = !succ && (total_new >= cfg.max_samples);

  assign ctl.load = start;
  assign ctl.upd  = upd;
  assign ctl.clr  = upd && fail;

  always_comb begin
    running_nxt = running_r;
    still_nxt   = still_r;
    total_nxt   = total_r;
    flags       = '0;
    if (start) begin
      running_nxt = 1'b1;
      still_nxt   = '0;
      total_nxt   = '0;
      flags.busy  = 1'b1;
    end else if (upd) begin
      running_nxt   = !(succ || fail);
      still_nxt     = still_new;
      total_nxt     = total_new;
      flags.busy    = !(succ || fail);
      flags.done    = succ || fail;
      flags.success = succ;
      flags.motion  = any_motion;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      still_r   <= '0;
      total_r   <= '0;
    end else begin
      running_r <= running_nxt;
      still_r   <= still_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

@@ hdl/gbc_obuf.sv @@
// Result buffer of the gyro bias calibrator: output register plus one skid entry.
// Depends on gbc_pkg.

module gbc_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gbc_pkg::gbc_out_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gbc_pkg::gbc_out_t out_data
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  gbc_pkg::gbc_out_t out_data_r;
  gbc_pkg::gbc_out_t out_data_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  gbc_pkg::gbc_out_t skid_data_r;
  gbc_pkg::gbc_out_t skid_data_nxt;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

@@ hdl/gyro_bias_calibrator.sv @@
// Top level of the gyro zero-rate bias calibrator.
// Depends on gbc_pkg, gbc_lane, gbc_ctrl and gbc_obuf.
//
// Usage: the input channel (in_valid, in_ready, in_data) carries one item per
// handshake. An item with op at start begins a calibration run; an item with op
// at sample delivers one reading per axis. Every accepted item yields exactly
// one result item on the output channel (out_valid, out_ready, out_data) with
// the run flags and the bias estimate of all three axes after that item. The
// user must write registers via cfg_we, cfg_addr and cfg_wdata only while no
// item is in flight; the block does not enforce it. Unused indexes drop writes.
//
// A result is registered in the output register, or in the skid entry while the
// receiver stalls. The block takes one item per cycle while in_ready is high,
// set by the per-axis tracker and low-pass update, which computes the next lane
// state combinationally so that the next sample sees it at once. The three axis
// lanes run in parallel and the run control merges their motion flags.
//
// Reset clears bias, trackers, counters and the running flag, loads the register
// defaults and empties the result buffer. When the receiver stalls, the output
// register holds its result and one more item is taken into a skid entry; after
// that in_ready drops until the receiver takes a result.

module gyro_bias_calibrator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gbc_pkg::gbc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gbc_pkg::gbc_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [gbc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  gbc_pkg::gbc_cfg_t      cfg_r;
  gbc_pkg::gbc_cfg_t      cfg_nxt;
  gbc_pkg::gbc_lane_ctl_t lane_ctl;
  gbc_pkg::gbc_flags_t    flags;
  gbc_pkg::gbc_out_t      res;

  logic                     fire;
  logic [gbc_pkg::AXES-1:0] lane_motion;
  logic signed [15:0]       rate     [gbc_pkg::AXES];
  logic signed [31:0]       bias_nxt [gbc_pkg::AXES];

  assign fire = in_valid && in_ready;

  // Configuration registers. Bits above a register's width are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (gbc_pkg::gbc_reg_t'(cfg_addr))
        gbc_pkg::REG_STILL_SAMPLES: cfg_nxt.still_samples = cfg_wdata;
        gbc_pkg::REG_MAX_SAMPLES:   cfg_nxt.max_samples   = cfg_wdata;
        gbc_pkg::REG_TRACK_STEP:    cfg_nxt.track_step    = cfg_wdata;
        gbc_pkg::REG_TRACK_CLAMP:   cfg_nxt.track_clamp   = cfg_wdata[14:0];
        gbc_pkg::REG_MOTION_MARGIN: cfg_nxt.motion_margin = cfg_wdata[14:0];
        gbc_pkg::REG_BIAS_GAIN:     cfg_nxt.bias_gain     = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.still_samples <= gbc_pkg::STILL_SAMPLES_RST;
      cfg_r.max_samples   <= gbc_pkg::MAX_SAMPLES_RST;
      cfg_r.track_step    <= gbc_pkg::TRACK_STEP_RST;
      cfg_r.track_clamp   <= gbc_pkg::TRACK_CLAMP_RST;
      cfg_r.motion_margin <= gbc_pkg::MOTION_MARGIN_RST;
      cfg_r.bias_gain     <= gbc_pkg::BIAS_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Axis order of the lanes follows the field order of the item.
  assign rate[0] = in_data.rate_x;
  assign rate[1] = in_data.rate_y;
  assign rate[2] = in_data.rate_z;

  for (genvar a = 0; a < gbc_pkg::AXES; a++) begin : g_lane
    gbc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .cfg      (cfg_r),
      .rate     (rate[a]),
      .motion   (lane_motion[a]),
      .bias_nxt (bias_nxt[a])
    );
  end

  // The run control sees all lane motion flags and tells the lanes whether
  // a timed-out run must zero the bias.
  gbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .op          (in_data.op),
    .lane_motion (lane_motion),
    .cfg         (cfg_r),
    .ctl         (lane_ctl),
    .flags       (flags)
  );

  always_comb begin
    res.busy_res = flags.busy;
    res.done_res = flags.done;
    res.success  = flags.success;
    res.motion   = flags.motion;
    res.bias_x   = bias_nxt[0];
    res.bias_y   = bias_nxt[1];
    res.bias_z   = bias_nxt[2];
  end

  gbc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ hdl/gbc_checker.sv @@
// Port-level checks of the gyro bias calibrator, bound to the top level.
// Depends on gbc_pkg and gyro_bias_calibrator.

module gbc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input gbc_pkg::gbc_out_t out_data
);

  // A stalled result keeps its place and value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result either ends a run or leaves it running, never both.
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.busy_res && out_data.done_res))
    else $error("busy and done together");

  // Success is reported only on the item that ends a run.
  a_succ_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.success |-> out_data.done_res)
    else $error("success without done");

  // An ignored sample never reports motion.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res && !out_data.done_res |-> !out_data.motion)
    else $error("motion on an idle item");

  // A run that times out leaves every bias at zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res && !out_data.success |->
      out_data.bias_x == 32'sd0 && out_data.bias_y == 32'sd0 &&
      out_data.bias_z == 32'sd0)
    else $error("bias not cleared after a failed run");

endmodule

bind gyro_bias_calibrator gbc_checker u_gbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the gyro bias calibrator.
// Depends on gbc_pkg and gyro_bias_calibrator.
// Expected results come from a cycle-free predictor kept in this bench.
`timescale 1ns / 1ps

module tb_top;

  // Longest random pause of the sender or stall of the receiver.
  localparam int GAP_MAX = 18;
  // Length of the one long receiver hold that fills the block and stalls its input.
  localparam int HOLD_CYCLES = 60;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Spare time after the drain lets any stray result show up.
  localparam int SETTLE_CYCLES = 4;
  localparam int RAND_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 50;
  // Phases that carry the two pressure cases.
  localparam int HOLD_PHASE = 2;
  localparam int PAUSE_PHASE = 5;
  // Both run counters stop at this value.
  localparam int unsigned COUNT_CAP = 65535;
  // An index past the register list; the block must drop writes to it.
  localparam logic [gbc_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam int ERR_PRINT_MAX = 40;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  gbc_pkg::gbc_in_t               in_data;
  logic                           out_valid;
  logic                           out_ready;
  gbc_pkg::gbc_out_t              out_data;
  logic                           cfg_we;
  logic [gbc_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [gbc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gyro_bias_calibrator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calibration predictor. It keeps its own copy of the registers and of the
  // per-axis bias and tracker, and is stepped once for every accepted item.
  // ---------------------------------------------------------------------------
  gbc_pkg::gbc_cfg_t  cal_cfg;
  logic signed [31:0] est_bias  [gbc_pkg::AXES];
  logic signed [31:0] est_track [gbc_pkg::AXES];
  int unsigned        est_still;
  int unsigned        est_total;
  bit                 est_running;

  // Results still owed by the block, oldest first.
  gbc_pkg::gbc_out_t results_due [$];

  int  err_count;
  int  result_count;
  int  quiet_cycles;
  bit  idle_on;
  bit  hold_req;

  function automatic gbc_pkg::gbc_out_t cal_step(gbc_pkg::gbc_in_t it);
    gbc_pkg::gbc_out_t  r;
    logic signed [15:0] rate [gbc_pkg::AXES];
    longint             s, t, lim, mg, stp, gain, b, nb, mag_s, mag_t;
    bit                 moved;
    r = '0;
    moved = 1'b0;
    rate[0] = it.rate_x;
    rate[1] = it.rate_y;
    rate[2] = it.rate_z;
    if (it.op == gbc_pkg::OP_START) begin
      // A start always (re)loads the trackers from the stored bias.
      for (int i = 0; i < gbc_pkg::AXES; i++) est_track[i] = est_bias[i];
      est_still = 0;
      est_total = 0;
      est_running = 1'b1;
      r.busy_res = 1'b1;
    end else if (est_running) begin
      lim = cal_cfg.track_clamp;
      lim = lim * 65536;
      mg = cal_cfg.motion_margin;
      mg = mg * 65536;
      stp = cal_cfg.track_step;
      gain = cal_cfg.bias_gain;
      for (int i = 0; i < gbc_pkg::AXES; i++) begin
        s = rate[i];
        s = s * 65536;
        t = est_track[i];
        // The two steps are taken in turn, so an overshoot can step back.
        if (s > t) t = t + stp;
        if (s < t) t = t - stp;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        est_track[i] = t[31:0];
        mag_s = (s < 0) ? -s : s;
        mag_t = (t < 0) ? -t : t;
        if (mag_s > mg + mag_t) begin
          moved = 1'b1;
        end else begin
          // Low-pass toward the sample; the arithmetic shift floors.
          b = est_bias[i];
          nb = b + (((s - b) * gain) >>> 16);
          if (nb > 64'sd2147483647) nb = 64'sd2147483647;
          if (nb < -64'sd2147483648) nb = -64'sd2147483648;
          est_bias[i] = nb[31:0];
        end
      end
      if (moved) begin
        est_still = 0;
      end else if (est_still < COUNT_CAP) begin
        est_still++;
      end
      if (est_total < COUNT_CAP) est_total++;
      // Success wins when both limits are reached on the same sample.
      if (est_still >= cal_cfg.still_samples) begin
        est_running = 1'b0;
        r.done_res = 1'b1;
        r.success = 1'b1;
      end else if (est_total >= cal_cfg.max_samples) begin
        est_running = 1'b0;
        r.done_res = 1'b1;
        for (int i = 0; i < gbc_pkg::AXES; i++) est_bias[i] = '0;
      end else begin
        r.busy_res = 1'b1;
      end
    end
    // A sample while idle falls through here and leaves every state alone.
    r.motion = moved;
    r.bias_x = est_bias[0];
    r.bias_y = est_bias[1];
    r.bias_z = est_bias[2];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  task automatic report_error(string msg);
    if (err_count < ERR_PRINT_MAX) $display("ERROR result %0d: %s", result_count, msg);
    err_count++;
  endtask

  task automatic check_result(gbc_pkg::gbc_out_t got, gbc_pkg::gbc_out_t want);
    if (got.busy_res !== want.busy_res)
      report_error($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
    if (got.done_res !== want.done_res)
      report_error($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
    if (got.success !== want.success)
      report_error($sformatf("success %b, expected %b", got.success, want.success));
    if (got.motion !== want.motion)
      report_error($sformatf("motion %b, expected %b", got.motion, want.motion));
    if (got.bias_x !== want.bias_x)
      report_error($sformatf("bias_x %h, expected %h", got.bias_x, want.bias_x));
    if (got.bias_y !== want.bias_y)
      report_error($sformatf("bias_y %h, expected %h", got.bias_y, want.bias_y));
    if (got.bias_z !== want.bias_z)
      report_error($sformatf("bias_z %h, expected %h", got.bias_z, want.bias_z));
  endtask

  // Every accepted result is matched against the oldest outstanding item.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_error("result item with no item outstanding");
      end else begin
        check_result(out_data, results_due.pop_front());
      end
      result_count++;
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("gyro_bias_calibrator test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Stalls come in random bursts while idling is on. On request it
  // holds off for a long stretch so that the output and skid entries fill up
  // and in_ready drops while the sender keeps offering items.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, GAP_MAX) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks start and end at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(gbc_pkg::gbc_in_t it, bit typed, gbc_pkg::gbc_out_t want);
    gbc_pkg::gbc_out_t calc;
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = cal_step(it);
    // Queued after the edge, so the monitor never races the push.
    @(negedge clk);
    results_due.push_back(typed ? want : calc);
  endtask

  task automatic idle_gap(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Waits until every outstanding item has its result, then lets the block settle.
  task automatic wait_drain();
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [gbc_pkg::CFG_ADDR_W-1:0] idx,
                           logic [gbc_pkg::CFG_DATA_W-1:0] v);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = v;
    // Bits above a register's width are dropped, as are unused indexes.
    case (idx)
      gbc_pkg::REG_STILL_SAMPLES: cal_cfg.still_samples = v;
      gbc_pkg::REG_MAX_SAMPLES:   cal_cfg.max_samples = v;
      gbc_pkg::REG_TRACK_STEP:    cal_cfg.track_step = v;
      gbc_pkg::REG_TRACK_CLAMP:   cal_cfg.track_clamp = v[14:0];
      gbc_pkg::REG_MOTION_MARGIN: cal_cfg.motion_margin = v[14:0];
      gbc_pkg::REG_BIAS_GAIN:     cal_cfg.bias_gain = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly a value in the useful range, sometimes one of the register's extremes.
  function automatic logic [15:0] pick_reg(int lo, int hi, int tlo, int thi);
    case ($urandom_range(0, 7))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(thi, tlo));
    endcase
  endfunction

  // A still reading: the current bias estimate plus a little noise.
  function automatic logic signed [15:0] rate_near(logic signed [31:0] b, int spread);
    int c;
    int r;
    r = $urandom_range(0, 2 * spread);
    c = (b >>> 16) + r - spread;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c[15:0];
  endfunction

  // Random items follow the shape of a real calibration: a start, then
  // mostly still readings, with some motion, restarts and stray samples.
  function automatic gbc_pkg::gbc_in_t draw_item();
    gbc_pkg::gbc_in_t it;
    int               pick;
    int               spread;
    pick = $urandom_range(0, 99);
    it.op = gbc_pkg::OP_SAMPLE;
    it.rate_x = 16'($urandom);
    it.rate_y = 16'($urandom);
    it.rate_z = 16'($urandom);
    if (!est_running) begin
      if (pick < 85) it.op = gbc_pkg::OP_START;
    end else if (pick < 3) begin
      it.op = gbc_pkg::OP_START;
    end else if (pick >= 18) begin
      spread = $urandom_range(0, 24);
      it.rate_x = rate_near(est_bias[0], spread);
      it.rate_y = rate_near(est_bias[1], spread);
      it.rate_z = rate_near(est_bias[2], spread);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: a table of register writes and items, walked in order.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                             is_write;
    logic [gbc_pkg::CFG_ADDR_W-1:0] idx;
    logic [15:0]                    wdata;
    gbc_pkg::gbc_in_t               item;
    bit                             typed;
    gbc_pkg::gbc_out_t              want;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic add_write(logic [gbc_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] v);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.idx = idx;
    row.wdata = v;
    plan.push_back(row);
  endtask

  task automatic add_item(gbc_pkg::gbc_op_t op, int x, int y, int z);
    plan_row_t row;
    row = '{default: '0};
    row.item.op = op;
    row.item.rate_x = x[15:0];
    row.item.rate_y = y[15:0];
    row.item.rate_z = z[15:0];
    plan.push_back(row);
  endtask

  // Same as add_item, with the result read off by hand: flags, then zero bias.
  task automatic add_known(gbc_pkg::gbc_op_t op, int x, int y, int z, logic [3:0] flags);
    add_item(op, x, y, z);
    plan[$].typed = 1'b1;
    plan[$].want = '0;
    {plan[$].want.busy_res, plan[$].want.done_res,
     plan[$].want.success, plan[$].want.motion} = flags;
  endtask

  initial begin
    gbc_pkg::gbc_in_t it;
    logic [15:0]      v;
    bit               counts;
    int               done_items;

    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    err_count = 0;
    result_count = 0;
    quiet_cycles = 0;

    cal_cfg = '{still_samples: gbc_pkg::STILL_SAMPLES_RST,
                max_samples:   gbc_pkg::MAX_SAMPLES_RST,
                track_step:    gbc_pkg::TRACK_STEP_RST,
                track_clamp:   gbc_pkg::TRACK_CLAMP_RST,
                motion_margin: gbc_pkg::MOTION_MARGIN_RST,
                bias_gain:     gbc_pkg::BIAS_GAIN_RST};
    for (int i = 0; i < gbc_pkg::AXES; i++) begin
      est_bias[i] = '0;
      est_track[i] = '0;
    end
    est_still = 0;
    est_total = 0;
    est_running = 1'b0;

    // Out of reset nothing runs: a sample is ignored and a start reports busy.
    add_known(gbc_pkg::OP_SAMPLE, 32767, -32768, 0, 4'b0000);
    add_known(gbc_pkg::OP_START, 0, 0, 0, 4'b1000);
    add_item(gbc_pkg::OP_SAMPLE, 32767, -32768, 1);
    add_item(gbc_pkg::OP_SAMPLE, 0, 0, 0);
    add_item(gbc_pkg::OP_SAMPLE, -1, 1, 16384);
    // A start in the middle of a run restarts it from the stored bias.
    add_item(gbc_pkg::OP_START, -32768, 32767, -1);
    add_item(gbc_pkg::OP_SAMPLE, 5, -5, 0);
    // Widest tracker step, clamp, margin and gain; bit 15 is beyond the
    // 15-bit registers and must be dropped, as must the unused index.
    add_write(gbc_pkg::REG_STILL_SAMPLES, 16'd3);
    add_write(gbc_pkg::REG_TRACK_STEP, 16'hFFFF);
    add_write(gbc_pkg::REG_TRACK_CLAMP, 16'hFFFF);
    add_write(gbc_pkg::REG_MOTION_MARGIN, 16'hFFFF);
    add_write(gbc_pkg::REG_BIAS_GAIN, 16'hFFFF);
    add_write(REG_UNUSED, 16'h1234);
    add_item(gbc_pkg::OP_START, 0, 0, 0);
    // Most negative reading just beats the widest margin.
    add_item(gbc_pkg::OP_SAMPLE, -32768, 32767, 0);
    add_item(gbc_pkg::OP_SAMPLE, 100, -100, 5);
    add_item(gbc_pkg::OP_SAMPLE, 100, -100, 5);
    add_item(gbc_pkg::OP_SAMPLE, 100, -100, 5);
    // Still limit at zero ends the run on its first sample; with the clamp at
    // zero the tracker, loaded from a large bias, is clamped on that sample.
    add_write(gbc_pkg::REG_STILL_SAMPLES, 16'd0);
    add_write(gbc_pkg::REG_TRACK_CLAMP, 16'd0);
    add_item(gbc_pkg::OP_START, 1, 2, 3);
    add_item(gbc_pkg::OP_SAMPLE, 7, -7, 7);
    // Total limit at zero: the first sample times out and zeroes the bias.
    add_write(gbc_pkg::REG_STILL_SAMPLES, 16'hFFFF);
    add_write(gbc_pkg::REG_MAX_SAMPLES, 16'd0);
    add_write(gbc_pkg::REG_TRACK_STEP, 16'd0);
    add_write(gbc_pkg::REG_MOTION_MARGIN, 16'd0);
    add_write(gbc_pkg::REG_BIAS_GAIN, 16'd0);
    add_item(gbc_pkg::OP_START, 0, 0, 0);
    add_known(gbc_pkg::OP_SAMPLE, 0, 0, 0, 4'b0100);
    // A short timeout run with motion on its first sample.
    add_write(gbc_pkg::REG_STILL_SAMPLES, 16'd5);
    add_write(gbc_pkg::REG_MAX_SAMPLES, 16'd4);
    add_write(gbc_pkg::REG_TRACK_STEP, gbc_pkg::TRACK_STEP_RST);
    add_write(gbc_pkg::REG_TRACK_CLAMP, 16'd800);
    add_write(gbc_pkg::REG_MOTION_MARGIN, 16'd100);
    add_write(gbc_pkg::REG_BIAS_GAIN, 16'd131);
    add_item(gbc_pkg::OP_START, 0, 0, 0);
    add_item(gbc_pkg::OP_SAMPLE, 200, 0, 0);
    add_item(gbc_pkg::OP_SAMPLE, 3, 3, 3);
    add_item(gbc_pkg::OP_SAMPLE, -3, 2, 1);
    add_item(gbc_pkg::OP_SAMPLE, 0, 0, 0);
    add_item(gbc_pkg::OP_SAMPLE, -32768, 32767, -32768);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        wait_drain();
        write_reg(plan[k].idx, plan[k].wdata);
      end else begin
        if (idle_on && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, GAP_MAX));
        send_item(plan[k].item, plan[k].typed, plan[k].want);
      end
    end

    // Random phases, each under a fresh register setting. Idling is off in the
    // hold phase, so the receiver hold really backs up the input, and in the
    // last phase; the other phases idle most of the time.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drain();
      write_reg(gbc_pkg::REG_STILL_SAMPLES, pick_reg(1, 65535, 1, 24));
      write_reg(gbc_pkg::REG_MAX_SAMPLES, pick_reg(1, 65535, 1, 60));
      write_reg(gbc_pkg::REG_TRACK_STEP, pick_reg(0, 65535, 0, 65535));
      v = pick_reg(0, 32767, 0, 2000);
      v[15] = 1'($urandom_range(0, 1));
      write_reg(gbc_pkg::REG_TRACK_CLAMP, v);
      v = pick_reg(0, 32767, 10, 300);
      v[15] = 1'($urandom_range(0, 1));
      write_reg(gbc_pkg::REG_MOTION_MARGIN, v);
      write_reg(gbc_pkg::REG_BIAS_GAIN, pick_reg(0, 65535, 0, 65535));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      idle_on = (p != RAND_PHASES - 1) && (p != HOLD_PHASE) && ($urandom_range(0, 3) != 0);

      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        if (p == HOLD_PHASE && done_items == 10) hold_req = 1'b1;
        // Sender stops offering items until every result is back.
        if (p == PAUSE_PHASE && done_items == 25) wait_drain();
        it = draw_item();
        // Samples that arrive while idle are ignored and do not count.
        counts = (it.op == gbc_pkg::OP_START) || est_running;
        if (idle_on && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, GAP_MAX));
        send_item(it, 1'b0, '0);
        if (counts) done_items++;
      end
    end

    wait_drain();
    if (results_due.size() != 0) report_error("results still outstanding at the end");
    if (err_count == 0) begin
      $display("gyro_bias_calibrator test passed");
    end else begin
      $display("gyro_bias_calibrator test failed");
    end
    $finish;
  end

endmodule
